// File: rtl/atlm_pkg.sv
// Shared types, constants and the arctangent table for the tilt limit monitor.
package atlm_pkg;

  localparam int CORDIC_STEPS_DEF    = 16;
  localparam int ANGLE_FRAC_BITS_DEF = 8;
  localparam int TABLE_FRAC          = 24;
  localparam int ROOT_ITERS          = 32;
  localparam int OUT_W               = 17;
  localparam int OUT_MAX             = 46080;
  localparam int CFG_AW              = 4;

  typedef enum logic [1:0] {
    REG_ROLL_OFFSET  = 2'd0,
    REG_PITCH_OFFSET = 2'd1,
    REG_ROLL_LIMIT   = 2'd2,
    REG_PITCH_LIMIT  = 2'd3
  } atlm_reg_t;

  typedef enum logic [2:0] {
    LN_IDLE,
    LN_SUM,
    LN_ROOT,
    LN_ROTATE,
    LN_ROUND,
    LN_DONE
  } atlm_lane_state_t;

  typedef struct packed {
    logic start;
    logic take;
  } atlm_lane_ctl_t;

  typedef struct packed {
    logic done;
  } atlm_lane_status_t;

  // Arctangent of 2^-i in degrees scaled by 2^24.
  function automatic logic [31:0] atan_deg(input logic [4:0] i);
    logic [31:0] r;
    case (i)
      5'd0:  r = 32'd754974720;
      5'd1:  r = 32'd445687602;
      5'd2:  r = 32'd235489089;
      5'd3:  r = 32'd119537938;
      5'd4:  r = 32'd60000934;
      5'd5:  r = 32'd30029717;
      5'd6:  r = 32'd15018523;
      5'd7:  r = 32'd7509720;
      5'd8:  r = 32'd3754917;
      5'd9:  r = 32'd1877466;
      5'd10: r = 32'd938734;
      5'd11: r = 32'd469367;
      5'd12: r = 32'd234684;
      5'd13: r = 32'd117342;
      5'd14: r = 32'd58672;
      5'd15: r = 32'd29335;
      5'd16: r = 32'd14668;
      5'd17: r = 32'd7334;
      5'd18: r = 32'd3667;
      5'd19: r = 32'd1833;
      5'd20: r = 32'd917;
      5'd21: r = 32'd458;
      5'd22: r = 32'd229;
      5'd23: r = 32'd115;
      default: r = 32'd0;
    endcase
    return r;
  endfunction

endpackage

// File: rtl/atlm_angle.sv
// One angle lane: sum of squares, digit-serial square root, vectoring CORDIC.
module atlm_angle #(
  parameter int CORDIC_STEPS    = atlm_pkg::CORDIC_STEPS_DEF,
  parameter int ANGLE_FRAC_BITS = atlm_pkg::ANGLE_FRAC_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  atlm_pkg::atlm_lane_ctl_t           ctl,
  input  logic signed [16:0]                 num,
  input  logic signed [15:0]                 a,
  input  logic signed [15:0]                 b,
  output atlm_pkg::atlm_lane_status_t        status,
  output logic signed [ANGLE_FRAC_BITS+7:0]  angle
);
  import atlm_pkg::*;

  localparam int IW    = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;
  localparam int AW    = ANGLE_FRAC_BITS + 8;
  localparam int SHIFT = TABLE_FRAC - ANGLE_FRAC_BITS;
  localparam logic signed [32:0] HALF = 33'sd1 <<< (SHIFT - 1);
  localparam logic signed [32:0] LIM  = 33'sd90 <<< ANGLE_FRAC_BITS;

  atlm_lane_state_t state, state_next;

  logic [31:0]        sq_a, sq_b, rad, root;
  logic [35:0]        rem;
  logic [4:0]         cnt;
  logic [IW-1:0]      ic;
  logic signed [35:0] x, y;
  logic signed [32:0] z;
  logic               nz;

  logic [35:0]        rem_t, trial;
  logic               fits;
  logic signed [35:0] dx, dy;
  logic signed [32:0] zs, zr;
  logic [31:0]        root_next;

  always_comb begin
    rem_t     = {rem[33:0], rad[31:30]};
    trial     = {2'b00, root, 2'b01};
    fits      = rem_t >= trial;
    root_next = {root[30:0], fits};
    dx        = y >>> ic;
    dy        = x >>> ic;
    zs        = z + HALF;
    zr        = zs >>> SHIFT;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= LN_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    status.done = state == LN_DONE;
    case (state)
      LN_IDLE:   if (ctl.start) state_next = LN_SUM;
      LN_SUM:    state_next = LN_ROOT;
      LN_ROOT:   if (cnt == 5'(ROOT_ITERS - 1)) state_next = LN_ROTATE;
      LN_ROTATE: if (ic == IW'(CORDIC_STEPS - 1)) state_next = LN_ROUND;
      LN_ROUND:  state_next = LN_DONE;
      LN_DONE:   if (ctl.take) state_next = LN_IDLE;
      default:   state_next = LN_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    case (state)
      LN_IDLE: begin
        sq_a <= 32'(a * a);
        sq_b <= 32'(b * b);
        y    <= 36'(num) <<< 16;
        nz   <= num != 17'sd0;
      end
      LN_SUM: begin
        rad  <= sq_a + sq_b;
        rem  <= '0;
        root <= '0;
        cnt  <= '0;
      end
      LN_ROOT: begin
        // The low half of the radicand is all zero, so zeros shift in.
        rem  <= fits ? rem_t - trial : rem_t;
        root <= root_next;
        rad  <= {rad[29:0], 2'b00};
        cnt  <= cnt + 5'd1;
        x    <= $signed({4'b0000, root_next});
        z    <= '0;
        ic   <= '0;
      end
      LN_ROTATE: begin
        if (!y[35]) begin
          x <= x + dx;
          y <= y - dy;
          z <= z + $signed({1'b0, atan_deg(5'(ic))});
        end else begin
          x <= x - dx;
          y <= y + dy;
          z <= z - $signed({1'b0, atan_deg(5'(ic))});
        end
        ic <= ic + IW'(1);
      end
      LN_ROUND: begin
        if (!nz) begin
          angle <= '0;
        end else if (zr > LIM) begin
          angle <= AW'(LIM);
        end else if (zr < -LIM) begin
          angle <= AW'(-LIM);
        end else begin
          angle <= AW'(zr);
        end
      end
      default: begin
      end
    endcase
  end

endmodule

// File: rtl/accel_tilt_limit_monitor_core.sv
// Top level of the accelerometer tilt limit monitor.
//
//  channel  | signals                                   | direction
//  in       | in_valid in_ready accel_x/y/z             | sample in
//  out      | out_valid out_ready roll/pitch_angle,     | result out
//           | tilted tilt_began tilt_cleared            |
//  cfg      | psel penable pwrite paddr pwdata prdata   | register access
//
// A result is loaded once its input transfer has passed the sum, root, rotate and
// round states of both lanes; the next sample can be taken in the cycle after the
// load. The square root resolves one bit per cycle and the CORDIC makes one rotation
// per cycle; roll and pitch run in two lanes side by side.
// Reset is synchronous and puts offsets at 0, limits at 7680 and clears was_tilted.
// A stalled output holds the finished lanes, and in_ready stays low until the
// result moves into the output register.
module accel_tilt_limit_monitor_core #(
  parameter int CORDIC_STEPS    = atlm_pkg::CORDIC_STEPS_DEF,
  parameter int ANGLE_FRAC_BITS = atlm_pkg::ANGLE_FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [15:0]                accel_x,
  input  logic signed [15:0]                accel_y,
  input  logic signed [15:0]                accel_z,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [atlm_pkg::OUT_W-1:0] roll_angle,
  output logic signed [atlm_pkg::OUT_W-1:0] pitch_angle,
  output logic                              tilted,
  output logic                              tilt_began,
  output logic                              tilt_cleared,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [atlm_pkg::CFG_AW-1:0]       paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready
);
  import atlm_pkg::*;

  localparam int AW = ANGLE_FRAC_BITS + 8;
  localparam int DW = ((AW > 16) ? AW : 16) + 1;
  localparam logic signed [DW-1:0] SAT = DW'(OUT_MAX);

  logic signed [15:0] roll_offset, pitch_offset;
  logic [15:0]        roll_limit, pitch_limit;
  logic               was_tilted;
  logic               busy;

  atlm_lane_ctl_t    ctl;
  atlm_lane_status_t roll_st, pitch_st;
  logic signed [AW-1:0] roll_raw, pitch_raw;

  logic signed [DW-1:0]    roll_d, pitch_d;
  logic signed [OUT_W-1:0] roll_s, pitch_s;
  logic [15:0]             roll_abs, pitch_abs;
  logic                    tilt_now, load;
  logic signed [16:0]      neg_x;

  assign pready   = 1'b1;
  assign in_ready = !busy;
  assign neg_x    = -17'(accel_x);
  assign load     = roll_st.done && pitch_st.done && (!out_valid || out_ready);
  assign ctl.start = in_valid && in_ready;
  assign ctl.take  = load;

  atlm_angle #(
    .CORDIC_STEPS(CORDIC_STEPS), .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)
  ) u_roll (
    .clk(clk), .rst(rst), .ctl(ctl), .num(17'(accel_y)), .a(accel_x), .b(accel_z),
    .status(roll_st), .angle(roll_raw)
  );

  atlm_angle #(
    .CORDIC_STEPS(CORDIC_STEPS), .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)
  ) u_pitch (
    .clk(clk), .rst(rst), .ctl(ctl), .num(neg_x), .a(accel_y), .b(accel_z),
    .status(pitch_st), .angle(pitch_raw)
  );

  always_comb begin
    roll_d  = DW'(roll_raw) - DW'(roll_offset);
    pitch_d = DW'(pitch_raw) - DW'(pitch_offset);
    if (roll_d > SAT) roll_s = OUT_W'(OUT_MAX);
    else if (roll_d < -SAT) roll_s = -OUT_W'(OUT_MAX);
    else roll_s = OUT_W'(roll_d);
    if (pitch_d > SAT) pitch_s = OUT_W'(OUT_MAX);
    else if (pitch_d < -SAT) pitch_s = -OUT_W'(OUT_MAX);
    else pitch_s = OUT_W'(pitch_d);
    roll_abs  = roll_s[OUT_W-1] ? 16'(-roll_s) : 16'(roll_s);
    pitch_abs = pitch_s[OUT_W-1] ? 16'(-pitch_s) : 16'(pitch_s);
    tilt_now  = (roll_abs > roll_limit) || (pitch_abs > pitch_limit);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy       <= 1'b0;
      out_valid  <= 1'b0;
      was_tilted <= 1'b0;
    end else begin
      if (ctl.start) begin
        busy <= 1'b1;
      end else if (load) begin
        busy <= 1'b0;
      end
      if (load) begin
        out_valid  <= 1'b1;
        was_tilted <= tilt_now;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      roll_angle   <= roll_s;
      pitch_angle  <= pitch_s;
      tilted       <= tilt_now;
      tilt_began   <= tilt_now && !was_tilted;
      tilt_cleared <= !tilt_now && was_tilted;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      roll_offset  <= '0;
      pitch_offset <= '0;
      roll_limit   <= 16'd7680;
      pitch_limit  <= 16'd7680;
    end else if (psel && penable && pwrite) begin
      case (atlm_reg_t'(paddr[3:2]))
        REG_ROLL_OFFSET:  roll_offset  <= $signed(pwdata[15:0]);
        REG_PITCH_OFFSET: pitch_offset <= $signed(pwdata[15:0]);
        REG_ROLL_LIMIT:   roll_limit   <= pwdata[15:0];
        REG_PITCH_LIMIT:  pitch_limit  <= pwdata[15:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (atlm_reg_t'(paddr[3:2]))
      REG_ROLL_OFFSET:  prdata = 32'(roll_offset);
      REG_PITCH_OFFSET: prdata = 32'(pitch_offset);
      REG_ROLL_LIMIT:   prdata = {16'd0, roll_limit};
      REG_PITCH_LIMIT:  prdata = {16'd0, pitch_limit};
      default:          prdata = '0;
    endcase
  end

endmodule

// File: rtl/atlm_checker.sv
// Port-level checks for the tilt limit monitor, bound to the top level.
module atlm_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [16:0] roll_angle,
  input logic               tilted,
  input logic               tilt_began,
  input logic               tilt_cleared
);

  a_began: assert property (@(posedge clk) disable iff (rst)
    out_valid && tilt_began |-> tilted)
    else $error("tilt_began without tilted");

  a_cleared: assert property (@(posedge clk) disable iff (rst)
    out_valid && tilt_cleared |-> !tilted)
    else $error("tilt_cleared while tilted");

  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second sample taken during work");

  a_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (roll_angle <= 17'sd46080) && (roll_angle >= -17'sd46080))
    else $error("roll angle out of range");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(roll_angle))
    else $error("stalled result changed");

endmodule

bind accel_tilt_limit_monitor_core atlm_checker u_atlm_checker (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .roll_angle(roll_angle),
  .tilted(tilted), .tilt_began(tilt_began), .tilt_cleared(tilt_cleared)
);
